FILE: rtl/fir_full_convolution_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fir_full_convolution block.
// Defined empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef FIR_FULL_CONVOLUTION_ASSERT_SVH
`define FIR_FULL_CONVOLUTION_ASSERT_SVH
`ifndef SYNTH
`define FC_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define FC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FC_ASSERT_HOLDS(label, clk, rst_n, cond)
`define FC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/fir_fc_pkg.sv
// ---------------------------------------------------------------------------
// fir_fc_pkg
// Types and constants shared by the full convolution FIR modules.
// ---------------------------------------------------------------------------
package fir_fc_pkg;

    localparam int TAPS      = 7;
    localparam int NUM_COEF  = 7;
    localparam int DL_DEPTH  = TAPS - 1;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int TAP_W     = 3;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int OUT_W     = 36;
    localparam int CFG_IDX_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 4'd1;

    localparam logic [TAP_W-1:0]  TAP_COUNT_RESET = 3'd1;
    localparam logic [COEF_W-1:0] COEF_0_RESET    = 18'd131071;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic [TAP_W-1:0]                 tap_count;
        logic [NUM_COEF-1:0][COEF_W-1:0]  coef;
    } t_cfg;

    // One filter operation: a value to push through the taps.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_output;
    } t_op;

    // A tap count of zero acts as one.
    function automatic logic [TAP_W-1:0] active_taps(input logic [TAP_W-1:0] tap_count);
        logic [TAP_W-1:0] t;
        t = (tap_count == '0) ? TAP_W'(1) : tap_count;
        return t;
    endfunction

endpackage

FILE: rtl/fir_full_convolution.sv
// ---------------------------------------------------------------------------
// fir_full_convolution
// Full linear convolution FIR with configurable taps and tail flush.
// ---------------------------------------------------------------------------
// The block takes one sample per cycle and gives one filtered output per
// cycle while the queue has room, the output is not held and no tail is
// being issued. An accepted sample passes through the two-entry operation
// queue, three multiply and adder-tree stages and the output register. A
// sample marked end_of_signal with T taps in use holds the input side
// while the front part issues the T-1 zero-fed tail operations; the final
// tail output is marked final_output and the delay line clears behind it.
// The user must write registers through the plain write port only while
// the block is idle; the block does not enforce this. Index 0 is tap_count,
// indexes 1 to 7 are coef_0 to coef_6, and other indexes are ignored.
module fir_full_convolution (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fir_fc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fir_fc_pkg::COEF_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [fir_fc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_end_of_signal,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [fir_fc_pkg::OUT_W-1:0] o_filtered,
    output logic                          o_final_output
);

    fir_fc_pkg::t_cfg r_cfg;
    fir_fc_pkg::t_op  front_op;
    fir_fc_pkg::t_op  queue_op;
    logic push, pop, queue_full, queue_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_count <= fir_fc_pkg::TAP_COUNT_RESET;
            for (int k = 0; k < fir_fc_pkg::NUM_COEF; k++) begin
                r_cfg.coef[k] <= (k == 0) ? fir_fc_pkg::COEF_0_RESET : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == fir_fc_pkg::REG_TAP_COUNT) begin
                r_cfg.tap_count <= i_cfg_data[fir_fc_pkg::TAP_W-1:0];
            end else begin
                for (int k = 0; k < fir_fc_pkg::NUM_COEF; k++) begin
                    if (i_cfg_index == fir_fc_pkg::REG_COEF_0 + fir_fc_pkg::CFG_IDX_W'(k)) begin
                        r_cfg.coef[k] <= i_cfg_data;
                    end
                end
            end
        end
    end

    fir_fc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_end_of_signal (i_end_of_signal),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_op            (front_op)
    );

    fir_fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_op    (queue_op)
    );

    fir_fc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_queue_empty  (queue_empty),
        .i_op           (queue_op),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_filtered     (o_filtered),
        .o_final_output (o_final_output)
    );

endmodule

FILE: rtl/fir_fc_queue.sv
// ---------------------------------------------------------------------------
// fir_fc_queue
// Two-entry register queue between the front and the back of the filter.
// ---------------------------------------------------------------------------
module fir_fc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fir_fc_pkg::t_op  i_op,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output fir_fc_pkg::t_op  o_op
);

    fir_fc_pkg::t_op r_mem [fir_fc_pkg::QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(fir_fc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "fir_full_convolution_assert.svh"

    `FC_ASSERT_HOLDS(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full))
    `FC_ASSERT_HOLDS(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && o_empty))

endmodule

FILE: rtl/fir_fc_front.sv
// ---------------------------------------------------------------------------
// fir_fc_front
// Accepts samples and expands the end of each signal into tail operations.
// ---------------------------------------------------------------------------
module fir_fc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fir_fc_pkg::t_cfg              i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [fir_fc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_end_of_signal,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output fir_fc_pkg::t_op               o_op
);

    typedef enum logic [1:0] {
        ST_TAKE = 2'b01,
        ST_TAIL = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [fir_fc_pkg::TAP_W-1:0] r_left, n_left;
    logic [fir_fc_pkg::TAP_W-1:0] taps;
    logic accept;

    assign taps = fir_fc_pkg::active_taps(i_cfg.tap_count);

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        accept     = 1'b0;
        o_op.sample       = '0;
        o_op.final_output = 1'b0;
        case (r_state)
            ST_TAKE: begin
                o_in_ready = !i_queue_full;
                accept     = i_in_valid && !i_queue_full;
                o_push     = accept;
                o_op.sample       = i_sample;
                o_op.final_output = i_end_of_signal && (taps == fir_fc_pkg::TAP_W'(1));
                if (accept && i_end_of_signal && (taps != fir_fc_pkg::TAP_W'(1))) begin
                    n_state = ST_TAIL;
                    n_left  = taps - fir_fc_pkg::TAP_W'(1);
                end
            end
            ST_TAIL: begin
                // Tail outputs are computed with zeros fed into the taps.
                o_push            = !i_queue_full;
                o_op.final_output = (r_left == fir_fc_pkg::TAP_W'(1));
                if (!i_queue_full) begin
                    n_left = r_left - fir_fc_pkg::TAP_W'(1);
                    if (r_left == fir_fc_pkg::TAP_W'(1)) begin
                        n_state = ST_TAKE;
                    end
                end
            end
            default: begin
                n_state = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

`include "fir_full_convolution_assert.svh"

    `FC_ASSERT_HOLDS(a_tail_blocks_input, i_clk, i_rst_n, !(r_state == ST_TAIL && o_in_ready))

endmodule

FILE: rtl/fir_fc_back.sv
// ---------------------------------------------------------------------------
// fir_fc_back
// Delay line, tap multipliers, adder tree and output register.
// ---------------------------------------------------------------------------
module fir_fc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fir_fc_pkg::t_cfg              i_cfg,
    input  logic                          i_queue_empty,
    input  fir_fc_pkg::t_op               i_op,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [fir_fc_pkg::OUT_W-1:0] o_filtered,
    output logic                          o_final_output
);

    localparam int PROD_W  = fir_fc_pkg::PROD_W;
    localparam int Q_W     = PROD_W + 1;
    localparam int R_W     = PROD_W + 2;
    localparam int DL_LAST = fir_fc_pkg::DL_DEPTH - 1;

    logic signed [fir_fc_pkg::SAMPLE_W-1:0] r_dl [fir_fc_pkg::DL_DEPTH];
    logic signed [PROD_W-1:0] r_p [fir_fc_pkg::NUM_COEF];
    logic signed [Q_W-1:0]    r_q [4];
    logic signed [R_W-1:0]    r_r [2];
    logic r_p_valid, r_q_valid, r_r_valid, r_o_valid;
    logic r_p_final, r_q_final, r_r_final, r_o_final;
    logic signed [fir_fc_pkg::OUT_W-1:0] r_filtered;
    logic [fir_fc_pkg::TAP_W-1:0] taps;
    logic advance;
    logic dl_zero;

    // The whole pipeline moves together unless the output item is held.
    assign advance = !(r_o_valid && !i_out_ready);
    assign o_pop   = advance && !i_queue_empty;
    assign taps    = fir_fc_pkg::active_taps(i_cfg.tap_count);
    assign dl_zero = (r_dl[0] == '0) && (r_dl[DL_LAST] == '0);

    assign o_out_valid    = r_o_valid;
    assign o_filtered     = r_filtered;
    assign o_final_output = r_o_final;

    // Delay line: shifts on each operation but a signal's last one, which clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fir_fc_pkg::DL_DEPTH; k++) begin
                r_dl[k] <= '0;
            end
        end else if (o_pop) begin
            if (i_op.final_output) begin
                for (int k = 0; k < fir_fc_pkg::DL_DEPTH; k++) begin
                    r_dl[k] <= '0;
                end
            end else begin
                r_dl[0] <= i_op.sample;
                for (int k = 1; k < fir_fc_pkg::DL_DEPTH; k++) begin
                    r_dl[k] <= r_dl[k-1];
                end
            end
        end
    end

    // Product stage: one multiplier per tap, unused taps give zero.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p[0] <= i_op.sample * $signed(i_cfg.coef[0]);
            for (int k = 1; k < fir_fc_pkg::NUM_COEF; k++) begin
                if (fir_fc_pkg::TAP_W'(k) < taps) begin
                    r_p[k] <= r_dl[k-1] * $signed(i_cfg.coef[k]);
                end else begin
                    r_p[k] <= '0;
                end
            end
            r_p_final <= i_op.final_output;

            r_q[0] <= Q_W'(r_p[0]) + Q_W'(r_p[1]);
            r_q[1] <= Q_W'(r_p[2]) + Q_W'(r_p[3]);
            r_q[2] <= Q_W'(r_p[4]) + Q_W'(r_p[5]);
            r_q[3] <= Q_W'(r_p[6]);
            r_q_final <= r_p_final;

            r_r[0] <= R_W'(r_q[0]) + R_W'(r_q[1]);
            r_r[1] <= R_W'(r_q[2]) + R_W'(r_q[3]);
            r_r_final <= r_q_final;

            r_filtered <= fir_fc_pkg::OUT_W'(r_r[0]) + fir_fc_pkg::OUT_W'(r_r[1]);
            r_o_final  <= r_r_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_p_valid <= o_pop;
            r_q_valid <= r_p_valid;
            r_r_valid <= r_q_valid;
            r_o_valid <= r_r_valid;
        end
    end

`include "fir_full_convolution_assert.svh"

    `FC_ASSERT_NEXT(a_dl_clears, i_clk, i_rst_n, o_pop && i_op.final_output, dl_zero)
    `FC_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, !advance, r_o_valid && $stable(r_filtered))

endmodule
